// ----- rtl/core/lurp_pkg.sv -----
// shared types, register indexes, status codes and saturation helpers
// for the point undistort and rectify pipeline; no dependencies
package lurp_pkg;

	localparam int LURP_ITERATIONS = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRINCIPAL_POINT,
		REG_INV_FOCAL,
		REG_RADIAL,
		REG_TANGENTIAL,
		REG_H00_H01,
		REG_H02_H10,
		REG_H11_H12,
		REG_H20_H21
	} lurp_reg_t;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_ZDIV = 2'd1,
		STATUS_SAT  = 2'd2
	} lurp_status_t;

	typedef struct packed {
		logic zdiv;
		logic sat;
	} lurp_flags_t;

	function automatic logic sat_hit(input logic signed [63:0] v);
		return (v > 64'(Q_MAX)) || (v < 64'(Q_MIN));
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'(Q_MAX)) begin
			r = Q_MAX;
		end else if (v < 64'(Q_MIN)) begin
			r = Q_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/lurp_div2.sv -----
// pipelined restoring divider: two signed numerators over one shared divisor,
// one quotient bit per stage, saturating 32-bit quotients; uses lurp_pkg
module lurp_div2 #(
	parameter int NW = 56,
	parameter int DW = 41,
	parameter int SW = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic signed [NW-1:0]   num_a,
	input  logic signed [NW-1:0]   num_b,
	input  logic signed [DW-1:0]   den,
	input  logic [SW-1:0]          side_in,
	output logic                   out_valid,
	output logic signed [31:0]     quo_a,
	output logic signed [31:0]     quo_b,
	output lurp_pkg::lurp_flags_t  flags,
	output logic [SW-1:0]          side_out
);
	import lurp_pkg::*;

	localparam int QW = 32;
	localparam int CW = NW + DW;

	logic [DW-1:0] mag_d;
	logic          den_zero;

	logic          st_v    [0:QW];
	logic [DW-1:0] st_d    [0:QW];
	logic          st_zero [0:QW];
	logic [SW-1:0] st_side [0:QW];

	logic [DW-1:0] st_rem  [0:1][0:QW];
	logic [QW-1:0] st_lo   [0:1][0:QW];
	logic [QW-1:0] st_q    [0:1][0:QW];
	logic          st_neg  [0:1][0:QW];
	logic          st_nneg [0:1][0:QW];
	logic          st_ovf  [0:1][0:QW];

	logic signed [31:0] quo_f  [0:1];
	logic               zdiv_f [0:1];
	logic               sat_f  [0:1];

	assign mag_d    = den[DW-1] ? (~den + 1'b1) : den;
	assign den_zero = (den == '0);

	// prep beat: magnitudes, signs, overflow screen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_v[0] <= 1'b0;
		end else if (en) begin
			st_v[0]    <= in_valid;
			st_d[0]    <= mag_d;
			st_zero[0] <= den_zero;
			st_side[0] <= side_in;
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic signed [NW-1:0] num;
		logic [NW-1:0]        mag_n;
		logic                 ovf;

		assign num   = (l == 0) ? num_a : num_b;
		assign mag_n = num[NW-1] ? (~num + 1'b1) : num;
		assign ovf   = CW'(mag_n[NW-1:QW]) >= CW'(mag_d);

		always_ff @(posedge clk) begin
			if (en) begin
				st_rem[l][0]  <= DW'(mag_n[NW-1:QW]);
				st_lo[l][0]   <= mag_n[QW-1:0];
				st_q[l][0]    <= '0;
				st_neg[l][0]  <= num[NW-1] ^ den[DW-1];
				st_nneg[l][0] <= num[NW-1];
				st_ovf[l][0]  <= ovf;
			end
		end

		for (genvar k = 0; k < QW; k++) begin : g_step
			logic [DW:0] t;
			logic [DW:0] diff;
			logic        ge;

			assign t    = {st_rem[l][k], st_lo[l][k][QW-1-k]};
			assign ge   = t >= {1'b0, st_d[k]};
			assign diff = t - {1'b0, st_d[k]};

			always_ff @(posedge clk) begin
				if (en) begin
					st_rem[l][k+1]  <= ge ? diff[DW-1:0] : t[DW-1:0];
					st_lo[l][k+1]   <= st_lo[l][k];
					st_q[l][k+1]    <= {st_q[l][k][QW-2:0], ge};
					st_neg[l][k+1]  <= st_neg[l][k];
					st_nneg[l][k+1] <= st_nneg[l][k];
					st_ovf[l][k+1]  <= st_ovf[l][k];
				end
			end
		end

		logic [QW-1:0]      q;
		logic               neg;
		logic signed [32:0] qs;

		assign q   = st_q[l][QW];
		assign neg = st_neg[l][QW];
		assign qs  = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

		always_comb begin
			zdiv_f[l] = 1'b0;
			sat_f[l]  = 1'b0;
			quo_f[l]  = qs[31:0];
			if (st_zero[QW]) begin
				zdiv_f[l] = 1'b1;
				quo_f[l]  = st_nneg[l][QW] ? Q_MIN : Q_MAX;
			end else if (st_ovf[l][QW] || (!neg && q[QW-1]) || (neg && q > 32'h80000000)) begin
				sat_f[l] = 1'b1;
				quo_f[l] = neg ? Q_MIN : Q_MAX;
			end
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				st_v[k+1] <= 1'b0;
			end else if (en) begin
				st_v[k+1]    <= st_v[k];
				st_d[k+1]    <= st_d[k];
				st_zero[k+1] <= st_zero[k];
				st_side[k+1] <= st_side[k];
			end
		end
	end

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid  <= st_v[QW];
			quo_a      <= quo_f[0];
			quo_b      <= quo_f[1];
			flags.zdiv <= zdiv_f[0] | zdiv_f[1];
			flags.sat  <= sat_f[0] | sat_f[1];
			side_out   <= st_side[QW];
		end
	end

endmodule

// ----- rtl/core/lens_undistort_rectify_point.sv -----
// one beat per cycle while no result is held by out_stall
// each undistort round is 5 arithmetic stages plus a 34-stage restoring divider,
// the homography adds 2 stages and another 34-stage divider
// the whole pipe advances unless a result is held by out_stall
// reset clears all valid bits and the calibration registers to zero
// top level of the point undistort and rectify pipeline; uses lurp_pkg and lurp_div2
module lens_undistort_rectify_point #(
	parameter int ITERATIONS = lurp_pkg::LURP_ITERATIONS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lurp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lurp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [31:0]               x_in,
	input  logic signed [31:0]               y_in,
	input  logic                             last_point,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [31:0]               x_out,
	output logic signed [31:0]               y_out,
	output logic                             last_point_out,
	output logic [1:0]                       status
);
	import lurp_pkg::*;

	localparam int SIDE_IT = 32 + 32 + 1 + $bits(lurp_flags_t);
	localparam int SIDE_H  = 1 + $bits(lurp_flags_t);

	logic en;
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	// calibration registers
	logic [63:0] principal_q, inv_focal_q, tangential_q;
	logic [62:0] radial_q;
	logic [63:0] h00_h01_q, h02_h10_q, h11_h12_q, h20_h21_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			principal_q  <= '0;
			inv_focal_q  <= '0;
			radial_q     <= '0;
			tangential_q <= '0;
			h00_h01_q    <= '0;
			h02_h10_q    <= '0;
			h11_h12_q    <= '0;
			h20_h21_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (lurp_reg_t'(cfg_index))
				REG_PRINCIPAL_POINT: principal_q <= cfg_data;
				REG_INV_FOCAL:       inv_focal_q <= cfg_data;
				REG_RADIAL:          radial_q <= cfg_data[62:0];
				REG_TANGENTIAL:      tangential_q <= cfg_data;
				REG_H00_H01:         h00_h01_q <= cfg_data;
				REG_H02_H10:         h02_h10_q <= cfg_data;
				REG_H11_H12:         h11_h12_q <= cfg_data;
				REG_H20_H21:         h20_h21_q <= cfg_data;
				default:             principal_q <= principal_q;
			endcase
		end
	end

	logic signed [31:0] cx, cy, ifx, ify, p1, p2;
	logic signed [20:0] k1, k2, k3;
	logic signed [31:0] h00, h01, h02, h10, h11, h12, h20, h21;

	assign cx  = principal_q[31:0];
	assign cy  = principal_q[63:32];
	assign ifx = inv_focal_q[31:0];
	assign ify = inv_focal_q[63:32];
	assign k1  = radial_q[20:0];
	assign k2  = radial_q[41:21];
	assign k3  = radial_q[62:42];
	assign p1  = tangential_q[31:0];
	assign p2  = tangential_q[63:32];
	assign h00 = h00_h01_q[31:0];
	assign h01 = h00_h01_q[63:32];
	assign h02 = h02_h10_q[31:0];
	assign h10 = h02_h10_q[63:32];
	assign h11 = h11_h12_q[31:0];
	assign h12 = h11_h12_q[63:32];
	assign h20 = h20_h21_q[31:0];
	assign h21 = h20_h21_q[63:32];

	// normalize: subtract principal point, scale by inverse focal length
	logic signed [32:0] dx, dy;
	logic signed [64:0] px, py;
	logic signed [63:0] nx, ny;

	assign dx = 33'(x_in) - 33'(cx);
	assign dy = 33'(y_in) - 33'(cy);
	assign px = dx * ifx;
	assign py = dy * ify;
	assign nx = 64'(px >>> 22);
	assign ny = 64'(py >>> 22);

	logic               v_s1;
	logic signed [31:0] u0_s1, v0_s1;
	lurp_flags_t        fl_s1;
	logic               last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1       <= in_valid;
			u0_s1      <= sat32(nx);
			v0_s1      <= sat32(ny);
			fl_s1.zdiv <= 1'b0;
			fl_s1.sat  <= sat_hit(nx) | sat_hit(ny);
			last_s1    <= last_point;
		end
	end

	// undistort rounds
	logic               it_v    [0:ITERATIONS];
	logic signed [31:0] it_u0   [0:ITERATIONS];
	logic signed [31:0] it_v0   [0:ITERATIONS];
	logic signed [31:0] it_u    [0:ITERATIONS];
	logic signed [31:0] it_w    [0:ITERATIONS];
	lurp_flags_t        it_fl   [0:ITERATIONS];
	logic               it_last [0:ITERATIONS];

	assign it_v[0]    = v_s1;
	assign it_u0[0]   = u0_s1;
	assign it_v0[0]   = v0_s1;
	assign it_u[0]    = u0_s1;
	assign it_w[0]    = v0_s1;
	assign it_fl[0]   = fl_s1;
	assign it_last[0] = last_s1;

	for (genvar g = 0; g < ITERATIONS; g++) begin : g_iter
		logic signed [31:0] u, v, u0, v0;
		lurp_flags_t        fl_in;
		logic               last_in;

		assign u       = it_u[g];
		assign v       = it_w[g];
		assign u0      = it_u0[g];
		assign v0      = it_v0[g];
		assign fl_in   = it_fl[g];
		assign last_in = it_last[g];

		// squares and cross term
		logic signed [63:0] m_uu, m_vv, m_uv;
		assign m_uu = 64'(u) * 64'(u);
		assign m_vv = 64'(v) * 64'(v);
		assign m_uv = 64'(u) * 64'(v);

		logic               v_s2;
		logic signed [39:0] squ_s2, sqv_s2, uvp_s2;
		logic signed [31:0] u0_s2, v0_s2;
		lurp_flags_t        fl_s2;
		logic               last_s2;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s2 <= 1'b0;
			end else if (en) begin
				v_s2    <= it_v[g];
				squ_s2  <= 40'(m_uu >>> 24);
				sqv_s2  <= 40'(m_vv >>> 24);
				uvp_s2  <= 40'(m_uv >>> 24);
				u0_s2   <= u0;
				v0_s2   <= v0;
				fl_s2   <= fl_in;
				last_s2 <= last_in;
			end
		end

		// radius and clamped terms
		logic signed [63:0] r2_w;
		assign r2_w = 64'(squ_s2) + 64'(sqv_s2);

		logic               v_s3;
		logic signed [31:0] r2_s3, uu_s3, vv_s3, uv_s3, u0_s3, v0_s3;
		lurp_flags_t        fl_s3;
		logic               last_s3;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s3 <= 1'b0;
			end else if (en) begin
				v_s3       <= v_s2;
				r2_s3      <= sat32(r2_w);
				uu_s3      <= sat32(64'(squ_s2));
				vv_s3      <= sat32(64'(sqv_s2));
				uv_s3      <= sat32(64'(uvp_s2));
				u0_s3      <= u0_s2;
				v0_s3      <= v0_s2;
				fl_s3.zdiv <= fl_s2.zdiv;
				fl_s3.sat  <= fl_s2.sat | sat_hit(r2_w) | sat_hit(64'(squ_s2))
					| sat_hit(64'(sqv_s2)) | sat_hit(64'(uvp_s2));
				last_s3    <= last_s2;
			end
		end

		// first polynomial step and tangential sums
		logic signed [63:0] m_k3, a_w, sx_w, sy_w;
		assign m_k3 = 64'(k3) * 64'(r2_s3);
		assign a_w  = (m_k3 >>> 18) + (64'(k2) <<< 6);
		assign sx_w = 64'(r2_s3) + (64'(uu_s3) <<< 1);
		assign sy_w = 64'(r2_s3) + (64'(vv_s3) <<< 1);

		logic               v_s4;
		logic signed [31:0] a_s4, sx_s4, sy_s4, r2_s4, uv_s4, u0_s4, v0_s4;
		lurp_flags_t        fl_s4;
		logic               last_s4;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s4 <= 1'b0;
			end else if (en) begin
				v_s4       <= v_s3;
				a_s4       <= sat32(a_w);
				sx_s4      <= sat32(sx_w);
				sy_s4      <= sat32(sy_w);
				r2_s4      <= r2_s3;
				uv_s4      <= uv_s3;
				u0_s4      <= u0_s3;
				v0_s4      <= v0_s3;
				fl_s4.zdiv <= fl_s3.zdiv;
				fl_s4.sat  <= fl_s3.sat | sat_hit(a_w) | sat_hit(sx_w) | sat_hit(sy_w);
				last_s4    <= last_s3;
			end
		end

		// second polynomial step and tangential offsets
		logic signed [63:0] m_ar, m_p1uv, m_p2sx, m_p1sy, m_p2uv, b_w, du_w, dv_w;
		assign m_ar   = 64'(a_s4) * 64'(r2_s4);
		assign m_p1uv = 64'(p1) * 64'(uv_s4);
		assign m_p2sx = 64'(p2) * 64'(sx_s4);
		assign m_p1sy = 64'(p1) * 64'(sy_s4);
		assign m_p2uv = 64'(p2) * 64'(uv_s4);
		assign b_w    = (m_ar >>> 24) + (64'(k1) <<< 6);
		assign du_w   = (m_p1uv >>> 29) + (m_p2sx >>> 30);
		assign dv_w   = (m_p1sy >>> 30) + (m_p2uv >>> 29);

		logic               v_s5;
		logic signed [31:0] b_s5, du_s5, dv_s5, r2_s5, u0_s5, v0_s5;
		lurp_flags_t        fl_s5;
		logic               last_s5;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s5 <= 1'b0;
			end else if (en) begin
				v_s5       <= v_s4;
				b_s5       <= sat32(b_w);
				du_s5      <= sat32(du_w);
				dv_s5      <= sat32(dv_w);
				r2_s5      <= r2_s4;
				u0_s5      <= u0_s4;
				v0_s5      <= v0_s4;
				fl_s5.zdiv <= fl_s4.zdiv;
				fl_s5.sat  <= fl_s4.sat | sat_hit(b_w) | sat_hit(du_w) | sat_hit(dv_w);
				last_s5    <= last_s4;
			end
		end

		// divisor and numerators
		logic signed [63:0] m_br, nu_w, nv_w;
		logic signed [31:0] nu_c, nv_c;
		assign m_br = 64'(b_s5) * 64'(r2_s5);
		assign nu_w = 64'(u0_s5) - 64'(du_s5);
		assign nv_w = 64'(v0_s5) - 64'(dv_s5);
		assign nu_c = sat32(nu_w);
		assign nv_c = sat32(nv_w);

		logic               v_s6;
		logic signed [40:0] den_s6;
		logic signed [55:0] nu_s6, nv_s6;
		logic signed [31:0] u0_s6, v0_s6;
		lurp_flags_t        fl_s6;
		logic               last_s6;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s6 <= 1'b0;
			end else if (en) begin
				v_s6       <= v_s5;
				den_s6     <= 41'sd16777216 + 41'(m_br >>> 24);
				nu_s6      <= {nu_c, 24'd0};
				nv_s6      <= {nv_c, 24'd0};
				u0_s6      <= u0_s5;
				v0_s6      <= v0_s5;
				fl_s6.zdiv <= fl_s5.zdiv;
				fl_s6.sat  <= fl_s5.sat | sat_hit(nu_w) | sat_hit(nv_w);
				last_s6    <= last_s5;
			end
		end

		logic [SIDE_IT-1:0] side_o;
		lurp_flags_t        dfl;

		lurp_div2 #(
			.NW(56),
			.DW(41),
			.SW(SIDE_IT)
		) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (v_s6),
			.num_a    (nu_s6),
			.num_b    (nv_s6),
			.den      (den_s6),
			.side_in  ({u0_s6, v0_s6, last_s6, fl_s6}),
			.out_valid(it_v[g+1]),
			.quo_a    (it_u[g+1]),
			.quo_b    (it_w[g+1]),
			.flags    (dfl),
			.side_out (side_o)
		);

		assign it_u0[g+1]   = side_o[SIDE_IT-1 -: 32];
		assign it_v0[g+1]   = side_o[SIDE_IT-33 -: 32];
		assign it_last[g+1] = side_o[$bits(lurp_flags_t)];
		assign it_fl[g+1]   = lurp_flags_t'(side_o[$bits(lurp_flags_t)-1:0] | dfl);
	end

	// homography products
	logic signed [31:0] uf, vf;
	assign uf = it_u[ITERATIONS];
	assign vf = it_w[ITERATIONS];

	logic signed [63:0] m00, m01, m10, m11, m20, m21;
	assign m00 = 64'(h00) * 64'(uf);
	assign m01 = 64'(h01) * 64'(vf);
	assign m10 = 64'(h10) * 64'(uf);
	assign m11 = 64'(h11) * 64'(vf);
	assign m20 = 64'(h20) * 64'(uf);
	assign m21 = 64'(h21) * 64'(vf);

	logic               v_h1;
	logic signed [39:0] t00_h1, t01_h1, t10_h1, t11_h1, t20_h1, t21_h1;
	lurp_flags_t        fl_h1;
	logic               last_h1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_h1 <= 1'b0;
		end else if (en) begin
			v_h1    <= it_v[ITERATIONS];
			t00_h1  <= 40'(m00 >>> 24);
			t01_h1  <= 40'(m01 >>> 24);
			t10_h1  <= 40'(m10 >>> 24);
			t11_h1  <= 40'(m11 >>> 24);
			t20_h1  <= 40'(m20 >>> 24);
			t21_h1  <= 40'(m21 >>> 24);
			fl_h1   <= it_fl[ITERATIONS];
			last_h1 <= it_last[ITERATIONS];
		end
	end

	// homogeneous sums, w cut to q.22
	logic signed [41:0] hx, hy, hw;
	assign hx = 42'(t00_h1) + 42'(t01_h1) + 42'(h02);
	assign hy = 42'(t10_h1) + 42'(t11_h1) + 42'(h12);
	assign hw = 42'(t20_h1) + 42'(t21_h1) + 42'sd1073741824;

	logic               v_h2;
	logic signed [63:0] nx_h2, ny_h2;
	logic signed [33:0] w_h2;
	lurp_flags_t        fl_h2;
	logic               last_h2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_h2 <= 1'b0;
		end else if (en) begin
			v_h2    <= v_h1;
			nx_h2   <= {hx, 22'd0};
			ny_h2   <= {hy, 22'd0};
			w_h2    <= 34'(hw >>> 8);
			fl_h2   <= fl_h1;
			last_h2 <= last_h1;
		end
	end

	logic [SIDE_H-1:0] side_h;
	lurp_flags_t       hfl, ofl;

	lurp_div2 #(
		.NW(64),
		.DW(34),
		.SW(SIDE_H)
	) u_div_h (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_h2),
		.num_a    (nx_h2),
		.num_b    (ny_h2),
		.den      (w_h2),
		.side_in  ({last_h2, fl_h2}),
		.out_valid(out_valid),
		.quo_a    (x_out),
		.quo_b    (y_out),
		.flags    (hfl),
		.side_out (side_h)
	);

	assign last_point_out = side_h[SIDE_H-1];
	assign ofl            = lurp_flags_t'(side_h[$bits(lurp_flags_t)-1:0] | hfl);

	always_comb begin
		priority if (ofl.zdiv) begin
			status = STATUS_ZDIV;
		end else if (ofl.sat) begin
			status = STATUS_SAT;
		end else begin
			status = STATUS_OK;
		end
	end

endmodule

// ----- rtl/core/lurp_checker.sv -----
// port-level checks for lens_undistort_rectify_point, attached by bind
// uses lurp_pkg for status codes
module lurp_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic signed [31:0]               x_out,
	input logic signed [31:0]               y_out,
	input logic                             last_point_out,
	input logic [1:0]                       status
);
	import lurp_pkg::*;

	// held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(x_out) && $stable(y_out)
			&& $stable(status) && $stable(last_point_out))
		else $error("result beat changed while stalled");

	// input is only held back by a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == STATUS_OK || status == STATUS_ZDIV || status == STATUS_SAT)
		else $error("undefined status code");

endmodule

bind lens_undistort_rectify_point lurp_checker u_lurp_checker (.*);
